### rtl/core/dcmf_pkg.sv
// shared constants, types and helpers of the dark channel minimum filter
// no dependencies; used by the channel interfaces and the top level

package dcmf_pkg;

	// default sizes of the line memory and the window
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_RADIUS_DEF = 7;
	localparam int MAX_HEIGHT     = 2048;

	// field and register widths
	localparam int PIX_W     = 8;
	localparam int COORD_W   = 11;
	localparam int ROW_W     = 12;
	localparam int CFG_W     = 12;
	localparam int RAD_W     = 3;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_RADIUS = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

	// request kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	localparam pix_t PIX_ONES = '1;

	function automatic pix_t min8(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

### rtl/core/dcmf_pix_if.sv
// input channel of the dark channel minimum filter: one pixel or flush request
// depends on dcmf_pkg

interface dcmf_pix_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	dcmf_pkg::pix_t     blue;
	dcmf_pkg::pix_t     green;
	dcmf_pkg::pix_t     red;

	modport source (output valid, req_type, blue, green, red, input ready);
	modport sink   (input valid, req_type, blue, green, red, output ready);
endinterface

### rtl/core/dcmf_res_if.sv
// output channel of the dark channel minimum filter: one filtered pixel
// depends on dcmf_pkg

interface dcmf_res_if;
	logic                           valid;
	logic                           ready;
	dcmf_pkg::pix_t                 dark_value;
	logic [dcmf_pkg::COORD_W-1:0]   out_col;
	logic [dcmf_pkg::COORD_W-1:0]   out_row;
	logic                           frame_last;

	modport source (output valid, dark_value, out_col, out_row, frame_last, input ready);
	modport sink   (input valid, dark_value, out_col, out_row, frame_last, output ready);
endinterface

### rtl/core/dark_channel_min_filter.sv
// dark channel minimum filter: per-pixel channel minimum, then a clipped square min window
// depends on dcmf_pkg, dcmf_pix_if and dcmf_res_if

// Takes one request per clock: BGR pixels in raster order, then flush requests once the
// frame is in. The result for raster position k leaves with the request numbered
// k + radius*width + radius of the frame (pixels and flushes counted alike), through the
// pipeline stages and an output register backed by one skid entry;
// ready drops only while that skid entry is occupied. The rate of one request per clock
// is set by the line memory: MAX_WIDTH entries, one per image column, each holding the
// channel minima of the last 2*MAX_RADIUS rows of that column, read once and written once
// per clock (read-modify-write with forwarding for back-to-back access to one column).
// Flush requests that arrive before the last pixel are dropped without effect, pixels
// that arrive after it act as flushes. The memory needs no clearing after reset; entries
// of rows outside the current frame are masked by row position. A listed register write
// aborts the frame in progress; the user must write only while the block is idle, which is
// not enforced. Width is clamped to 1..MAX_WIDTH, height to 1..2048, radius to MAX_RADIUS.

module dark_channel_min_filter #(
	parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = dcmf_pkg::MAX_RADIUS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dcmf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dcmf_pkg::CFG_W-1:0]        cfg_wr_data,
	dcmf_pix_if.sink                          pix,
	dcmf_res_if.source                        res
);

	// sizes derived from the parameters
	localparam int CA     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int RW     = $clog2(MAX_RADIUS + 1);
	localparam int HW     = WW + 1;
	localparam int SLOTS  = 2 * MAX_RADIUS;
	localparam int WIN    = 2 * MAX_RADIUS + 1;
	localparam int GRP    = (WIN + 3) / 4;
	localparam int NPAD   = GRP * 4;
	localparam int LW     = $clog2(WIN);
	localparam int DW     = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int PW     = dcmf_pkg::PIX_W;
	localparam int ENT_W  = SLOTS * PW;
	localparam int ROW_W  = dcmf_pkg::ROW_W;
	localparam int W_RST  = (dcmf_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : dcmf_pkg::RST_WIDTH;
	localparam int R_RST  = (dcmf_pkg::RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS
	                        : dcmf_pkg::RST_RADIUS;

	// ---------------------------------------------------------------------------
	// configuration, stored already clamped
	// ---------------------------------------------------------------------------
	logic [WW-1:0]    eff_w_q;
	logic [ROW_W-1:0] eff_h_q;
	logic [RW-1:0]    eff_r_q;

	logic [WW-1:0]    cfg_w_eff;
	logic [ROW_W-1:0] cfg_h_eff;
	logic [RW-1:0]    cfg_r_eff;
	logic             cfg_listed;

	always_comb begin
		if (cfg_wr_data == '0)
			cfg_w_eff = WW'(1);
		else if (32'(cfg_wr_data) > MAX_WIDTH)
			cfg_w_eff = WW'(MAX_WIDTH);
		else
			cfg_w_eff = WW'(cfg_wr_data);

		if (cfg_wr_data == '0)
			cfg_h_eff = ROW_W'(1);
		else if (32'(cfg_wr_data) > dcmf_pkg::MAX_HEIGHT)
			cfg_h_eff = ROW_W'(dcmf_pkg::MAX_HEIGHT);
		else
			cfg_h_eff = ROW_W'(cfg_wr_data);

		if (32'(cfg_wr_data[dcmf_pkg::RAD_W-1:0]) > MAX_RADIUS)
			cfg_r_eff = RW'(MAX_RADIUS);
		else
			cfg_r_eff = RW'(cfg_wr_data[dcmf_pkg::RAD_W-1:0]);
	end

	// only listed registers restart the frame
	always_comb begin
		unique case (cfg_index)
			dcmf_pkg::REG_FRAME_WIDTH,
			dcmf_pkg::REG_FRAME_HEIGHT,
			dcmf_pkg::REG_WINDOW_RADIUS: cfg_listed = cfg_wr_en;
			default:                     cfg_listed = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(W_RST);
			eff_h_q <= ROW_W'(dcmf_pkg::RST_HEIGHT);
			eff_r_q <= RW'(R_RST);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dcmf_pkg::REG_FRAME_WIDTH:   eff_w_q <= cfg_w_eff;
				dcmf_pkg::REG_FRAME_HEIGHT:  eff_h_q <= cfg_h_eff;
				dcmf_pkg::REG_WINDOW_RADIUS: eff_r_q <= cfg_r_eff;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------------
	// request intake and position tracking
	// ---------------------------------------------------------------------------
	// vcol/vrow: raster position of the request, continuing past the frame during flush
	// ocol/orow: position of the next result, cnt: requests before results start
	logic [CA-1:0]    vcol_q;
	logic [ROW_W-1:0] vrow_q;
	logic [CA-1:0]    ocol_q;
	logic [ROW_W-1:0] orow_q;
	logic [DW-1:0]    cnt_q;
	logic             done_q;

	logic             adv;
	logic             acc;
	logic             counted;
	logic             pixel_wr;
	logic             col_end;
	logic             row_last;
	logic [DW-1:0]    delay;
	logic             emit;
	logic             ocol_end;
	logic             last;
	logic [ROW_W-1:0] two_r;
	logic [ROW_W-1:0] lo_row;
	logic [ROW_W-1:0] base_row;
	logic [LW-1:0]    lim0;
	dcmf_pkg::pix_t   pix_min0;

	// the pipeline moves whenever the skid entry is free
	assign adv       = !skid_v_q;
	assign pix.ready = adv;
	assign acc       = pix.valid && adv;

	// early flushes are dropped, late pixels act as flushes
	assign counted  = done_q || (pix.req_type == dcmf_pkg::REQ_PIXEL);
	assign pixel_wr = !done_q && (pix.req_type == dcmf_pkg::REQ_PIXEL);

	assign col_end  = (WW'(vcol_q) + WW'(1)) == eff_w_q;
	assign row_last = vrow_q == (eff_h_q - ROW_W'(1));
	assign delay    = DW'(eff_r_q) * DW'(eff_w_q) + DW'(eff_r_q);
	assign emit     = cnt_q >= delay;
	assign ocol_end = (WW'(ocol_q) + WW'(1)) == eff_w_q;
	assign last     = ocol_end && (orow_q == (eff_h_q - ROW_W'(1)));

	// number of stored rows of this column that fall inside the vertical window:
	// the window spans rows vrow-2r .. vrow clipped to the frame
	assign two_r    = ROW_W'(eff_r_q) << 1;
	assign lo_row   = (vrow_q >= two_r) ? (vrow_q - two_r) : '0;
	assign base_row = pixel_wr ? vrow_q : eff_h_q;
	assign lim0     = LW'(base_row - lo_row);

	assign pix_min0 = dcmf_pkg::min8(dcmf_pkg::min8(pix.blue, pix.green), pix.red);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcol_q <= '0;
			vrow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (cfg_listed) begin
			vcol_q <= '0;
			vrow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (acc && counted) begin
			vcol_q <= col_end ? '0 : (vcol_q + CA'(1));
			if (col_end)
				vrow_q <= vrow_q + ROW_W'(1);
			if (pixel_wr && col_end && row_last)
				done_q <= 1'b1;
			if (!emit)
				cnt_q <= cnt_q + DW'(1);
			else begin
				ocol_q <= ocol_end ? '0 : (ocol_q + CA'(1));
				if (ocol_end)
					orow_q <= orow_q + ROW_W'(1);
			end
			// final result of the frame: everything back to the start
			if (emit && last) begin
				vcol_q <= '0;
				vrow_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
				cnt_q  <= '0;
				done_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// pipeline valid bits
	// ---------------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && counted;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 1: line memory read data, column update, vertical partial minima
	// ---------------------------------------------------------------------------
	logic [ENT_W-1:0] line_mem [MAX_WIDTH];
	logic [ENT_W-1:0] rd_q;

	logic             wr_s1;
	dcmf_pkg::pix_t   pix_s1;
	logic [CA-1:0]    col_s1;
	logic [LW-1:0]    lim_s1;
	logic             fwd_s1;
	logic [ENT_W-1:0] fwd_ent_s1;
	logic             emit_s1;
	logic [CA-1:0]    ocol_s1;
	logic [ROW_W-1:0] orow_s1;
	logic             last_s1;

	logic [ENT_W-1:0] ent;
	logic [ENT_W-1:0] new_ent;
	logic             mem_we;
	dcmf_pkg::pix_t   vvals [NPAD];
	dcmf_pkg::pix_t   vgrp  [GRP];
	logic [HW-1:0]    hpos;
	logic [WIN-1:0]   hmask;

	// a write in the same clock as the read of that column is forwarded
	assign ent     = fwd_s1 ? fwd_ent_s1 : rd_q;
	assign new_ent = {ent[ENT_W-PW-1:0], pix_s1};
	assign mem_we  = adv && v_s1 && wr_s1;

	always_ff @(posedge clk) begin
		if (adv)
			rd_q <= line_mem[vcol_q];
		if (mem_we)
			line_mem[col_s1] <= new_ent;
	end

	// rows above the frame or outside the window read as all ones
	always_comb begin
		for (int i = 0; i < NPAD; i++)
			vvals[i] = dcmf_pkg::PIX_ONES;
		vvals[0] = wr_s1 ? pix_s1 : dcmf_pkg::PIX_ONES;
		for (int j = 0; j < SLOTS; j++)
			vvals[j + 1] = (LW'(j) < lim_s1) ? ent[j*PW +: PW] : dcmf_pkg::PIX_ONES;
		for (int g = 0; g < GRP; g++) begin
			vgrp[g] = dcmf_pkg::PIX_ONES;
			for (int e = 0; e < 4; e++)
				vgrp[g] = dcmf_pkg::min8(vgrp[g], vvals[4*g + e]);
		end
	end

	// horizontal window: tap j holds column ocol + r - j, kept if inside the row
	assign hpos = HW'(ocol_s1) + HW'(eff_r_q);

	always_comb begin
		for (int j = 0; j < WIN; j++)
			hmask[j] = (HW'(j) <= (HW'(eff_r_q) << 1)) && (hpos >= HW'(j)) &&
			           (hpos < (HW'(eff_w_q) + HW'(j)));
	end

	// ---------------------------------------------------------------------------
	// stage 2: vertical minimum, pushed into the column minima taps
	// ---------------------------------------------------------------------------
	dcmf_pkg::pix_t   vgrp_s2 [GRP];
	logic [WIN-1:0]   hmask_s2;
	logic             emit_s2;
	logic [CA-1:0]    ocol_s2;
	logic [ROW_W-1:0] orow_s2;
	logic             last_s2;
	dcmf_pkg::pix_t   vmin;

	always_comb begin
		vmin = dcmf_pkg::PIX_ONES;
		for (int g = 0; g < GRP; g++)
			vmin = dcmf_pkg::min8(vmin, vgrp_s2[g]);
	end

	// ---------------------------------------------------------------------------
	// stage 3: masked horizontal partial minima over the taps
	// ---------------------------------------------------------------------------
	dcmf_pkg::pix_t   colmin_q [WIN];
	logic [WIN-1:0]   hmask_s3;
	logic             emit_s3;
	logic [CA-1:0]    ocol_s3;
	logic [ROW_W-1:0] orow_s3;
	logic             last_s3;
	dcmf_pkg::pix_t   hvals [NPAD];
	dcmf_pkg::pix_t   hgrp  [GRP];

	always_comb begin
		for (int i = 0; i < NPAD; i++)
			hvals[i] = dcmf_pkg::PIX_ONES;
		for (int j = 0; j < WIN; j++)
			hvals[j] = hmask_s3[j] ? colmin_q[j] : dcmf_pkg::PIX_ONES;
		for (int g = 0; g < GRP; g++) begin
			hgrp[g] = dcmf_pkg::PIX_ONES;
			for (int e = 0; e < 4; e++)
				hgrp[g] = dcmf_pkg::min8(hgrp[g], hvals[4*g + e]);
		end
	end

	// ---------------------------------------------------------------------------
	// stage 4: final minimum
	// ---------------------------------------------------------------------------
	dcmf_pkg::pix_t   hgrp_s4 [GRP];
	logic             emit_s4;
	logic [CA-1:0]    ocol_s4;
	logic [ROW_W-1:0] orow_s4;
	logic             last_s4;
	dcmf_pkg::pix_t   dark;
	logic             push;

	always_comb begin
		dark = dcmf_pkg::PIX_ONES;
		for (int g = 0; g < GRP; g++)
			dark = dcmf_pkg::min8(dark, hgrp_s4[g]);
	end

	assign push = adv && v_s4 && emit_s4;

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s1      <= pixel_wr;
			pix_s1     <= pix_min0;
			col_s1     <= vcol_q;
			lim_s1     <= lim0;
			fwd_s1     <= v_s1 && wr_s1 && (col_s1 == vcol_q);
			fwd_ent_s1 <= new_ent;
			emit_s1    <= emit;
			ocol_s1    <= ocol_q;
			orow_s1    <= orow_q;
			last_s1    <= last;

			vgrp_s2    <= vgrp;
			hmask_s2   <= hmask;
			emit_s2    <= emit_s1;
			ocol_s2    <= ocol_s1;
			orow_s2    <= orow_s1;
			last_s2    <= last_s1;

			hmask_s3   <= hmask_s2;
			emit_s3    <= emit_s2;
			ocol_s3    <= ocol_s2;
			orow_s3    <= orow_s2;
			last_s3    <= last_s2;

			hgrp_s4    <= hgrp;
			emit_s4    <= emit_s3;
			ocol_s4    <= ocol_s3;
			orow_s4    <= orow_s3;
			last_s4    <= last_s3;

			// every counted request moves the taps by one column
			if (v_s2) begin
				colmin_q[0] <= vmin;
				for (int j = 1; j < WIN; j++)
					colmin_q[j] <= colmin_q[j - 1];
			end
		end
	end

	// ---------------------------------------------------------------------------
	// output register and skid entry
	// ---------------------------------------------------------------------------
	logic                         out_v_q;
	logic                         skid_v_q;
	dcmf_pkg::pix_t               out_dark_q;
	logic [dcmf_pkg::COORD_W-1:0] out_col_q;
	logic [dcmf_pkg::COORD_W-1:0] out_row_q;
	logic                         out_last_q;
	dcmf_pkg::pix_t               skid_dark_q;
	logic [dcmf_pkg::COORD_W-1:0] skid_col_q;
	logic [dcmf_pkg::COORD_W-1:0] skid_row_q;
	logic                         skid_last_q;

	logic take;
	logic out_from_skid;
	logic out_from_pipe;
	logic skid_load;

	assign take          = out_v_q && res.ready;
	assign out_from_skid = skid_v_q && take;
	assign out_from_pipe = push && (!out_v_q || take);
	assign skid_load     = push && out_v_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_from_skid)
				skid_v_q <= 1'b0;
			else if (skid_load)
				skid_v_q <= 1'b1;
			if (out_from_skid || out_from_pipe)
				out_v_q <= 1'b1;
			else if (take)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_from_skid) begin
			out_dark_q <= skid_dark_q;
			out_col_q  <= skid_col_q;
			out_row_q  <= skid_row_q;
			out_last_q <= skid_last_q;
		end else if (out_from_pipe) begin
			out_dark_q <= dark;
			out_col_q  <= dcmf_pkg::COORD_W'(ocol_s4);
			out_row_q  <= dcmf_pkg::COORD_W'(orow_s4);
			out_last_q <= last_s4;
		end
		if (skid_load) begin
			skid_dark_q <= dark;
			skid_col_q  <= dcmf_pkg::COORD_W'(ocol_s4);
			skid_row_q  <= dcmf_pkg::COORD_W'(orow_s4);
			skid_last_q <= last_s4;
		end
	end

	assign res.valid      = out_v_q;
	assign res.dark_value = out_dark_q;
	assign res.out_col    = out_col_q;
	assign res.out_row    = out_row_q;
	assign res.frame_last = out_last_q;

	// ---------------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------------
	// the skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry occupied with empty output register");

	// a delivered position lies inside the configured frame
	a_out_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((32'(out_row_q) < 32'(eff_h_q)) && (32'(out_col_q) < 32'(eff_w_q))))
		else $error("result position outside the frame");

	// once the last pixel is in, the request position lies below the frame
	a_done_below_frame: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (vrow_q >= eff_h_q))
		else $error("frame marked complete before its last row");

endmodule
